>>> rtl/core/bpc_pkg.sv
// Shared types, constants and helpers for the barometric compensation block.
// Used by every module under rtl/core; has no dependencies of its own.
`default_nettype none

package bpc_pkg;

    localparam int DIV_STAGES  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = 3;

    // Register indexes on the configuration port.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4
    } reg_idx_t;

    localparam logic [31:0] C_TEMP_OFS  = 32'd8;
    localparam logic [31:0] C_B6_OFS    = 32'd4000;
    localparam logic [31:0] C_ROUND2    = 32'd2;
    localparam logic [31:0] C_AC4_OFS   = 32'd32768;
    localparam logic [31:0] C_UP_SCALE  = 32'd50000;
    localparam logic [31:0] C_P_SQ      = 32'd3038;
    localparam logic [31:0] C_P_LIN     = 32'hFFFF_E343; // -7357
    localparam logic [31:0] C_P_OFS     = 32'd3791;

    // Packed calibration words as written through the configuration port.
    typedef struct packed {
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
    } cal_t;

    // Context that travels beside the temperature divider.
    typedef struct packed {
        logic        vld;
        logic        err;
        logic        neg;
        logic [31:0] x1;
        logic [15:0] up;
    } div1_side_t;

    // Context that travels beside the pressure divider.
    typedef struct packed {
        logic        vld;
        logic        err;
        logic        big;
        logic [15:0] t;
    } div2_side_t;

    function automatic logic [31:0] sext16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    // Signed division by 2**k truncating toward zero.
    function automatic logic [31:0] sdiv_pow2(input logic [31:0] a, input logic [4:0] k);
        logic [31:0] bias;
        logic [31:0] sum;
        bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        sum  = a + bias;
        return $unsigned($signed(sum) >>> k);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bpc_regs.sv
// Calibration register file behind the APB-style configuration port.
// Depends on bpc_pkg.
`default_nettype none

module bpc_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bpc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output bpc_pkg::cal_t                   cal
);

    bpc_pkg::cal_t cal_reg;
    bpc_pkg::cal_t cal_next;
    logic [bpc_pkg::REG_IDX_W-1:0] idx;

    assign idx    = paddr[bpc_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign cal    = cal_reg;

    always_comb begin
        cal_next = cal_reg;
        if (psel && penable && pwrite) begin
            unique case (idx)
                bpc_pkg::REG_AC1_AC2: cal_next.ac1_ac2 = pwdata;
                bpc_pkg::REG_AC3_AC4: cal_next.ac3_ac4 = pwdata;
                bpc_pkg::REG_AC5_AC6: cal_next.ac5_ac6 = pwdata;
                bpc_pkg::REG_B1_B2:   cal_next.b1_b2   = pwdata;
                bpc_pkg::REG_MC_MD:   cal_next.mc_md   = pwdata;
                default:              cal_next         = cal_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bpc_pkg::REG_AC1_AC2: prdata = cal_reg.ac1_ac2;
            bpc_pkg::REG_AC3_AC4: prdata = cal_reg.ac3_ac4;
            bpc_pkg::REG_AC5_AC6: prdata = cal_reg.ac5_ac6;
            bpc_pkg::REG_B1_B2:   prdata = cal_reg.b1_b2;
            bpc_pkg::REG_MC_MD:   prdata = cal_reg.mc_md;
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bpc_queue.sv
// Input side: accepts raw sample pairs into a short queue for the datapath.
// Depends on bpc_pkg.
`default_nettype none

module bpc_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_raw_temperature,
    input  wire logic [15:0] s_raw_pressure,
    input  wire logic        pop,
    output logic             q_valid,
    output logic [15:0]      q_ut,
    output logic [15:0]      q_up
);

    localparam int CNT_W = bpc_pkg::QPTR_W + 1;

    logic [15:0] ut_mem_reg [0:bpc_pkg::QUEUE_DEPTH-1];
    logic [15:0] up_mem_reg [0:bpc_pkg::QUEUE_DEPTH-1];
    logic [bpc_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push, do_pop;

    assign s_ready = (count_reg != CNT_W'(bpc_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign do_pop  = pop && q_valid;
    assign q_ut    = ut_mem_reg[rd_ptr_reg];
    assign q_up    = up_mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ut_mem_reg[wr_ptr_reg] <= s_raw_temperature;
            up_mem_reg[wr_ptr_reg] <= s_raw_pressure;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + bpc_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + bpc_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bpc_div.sv
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// Depends on bpc_pkg.
`default_nettype none

module bpc_div (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic [31:0]      quotient
);

    localparam int N = bpc_pkg::DIV_STAGES;

    logic [31:0] rem_reg [0:N-1];
    logic [31:0] num_reg [0:N-1];
    logic [31:0] den_reg [0:N-1];
    logic [31:0] rem_next [0:N-1];
    logic [31:0] num_next [0:N-1];
    logic [31:0] den_next [0:N-1];

    always_comb begin
        logic [31:0] src_rem;
        logic [31:0] src_num;
        logic [31:0] src_den;
        logic [32:0] trial;
        logic [32:0] diff;
        for (int i = 0; i < N; i++) begin
            if (i == 0) begin
                src_rem = '0;
                src_num = dividend;
                src_den = divisor;
            end else begin
                src_rem = rem_reg[i-1];
                src_num = num_reg[i-1];
                src_den = den_reg[i-1];
            end
            trial = {src_rem, src_num[31]};
            diff  = trial - {1'b0, src_den};
            if (!diff[32]) begin
                rem_next[i] = diff[31:0];
                num_next[i] = {src_num[30:0], 1'b1};
            end else begin
                rem_next[i] = trial[31:0];
                num_next[i] = {src_num[30:0], 1'b0};
            end
            den_next[i] = src_den;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                rem_reg[i] <= rem_next[i];
                num_reg[i] <= num_next[i];
                den_reg[i] <= den_next[i];
            end
        end
    end

    assign quotient = num_reg[N-1];

endmodule

`default_nettype wire

>>> rtl/core/bpc_back.sv
// Compensation datapath: temperature, b5, pressure and the final correction.
// Depends on bpc_pkg and bpc_div; stalls as one unit on the output register.
`default_nettype none

module bpc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire bpc_pkg::cal_t cal,
    input  wire logic          q_valid,
    input  wire logic [15:0]   q_ut,
    input  wire logic [15:0]   q_up,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [15:0]        m_temperature_tenths,
    output logic [31:0]        m_pressure_pa,
    output logic               m_divide_error
);

    localparam int N = bpc_pkg::DIV_STAGES;

    logic adv;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    assign ac1 = bpc_pkg::sext16(cal.ac1_ac2[31:16]);
    assign ac2 = bpc_pkg::sext16(cal.ac1_ac2[15:0]);
    assign ac3 = bpc_pkg::sext16(cal.ac3_ac4[31:16]);
    assign ac4 = {16'd0, cal.ac3_ac4[15:0]};
    assign ac5 = {16'd0, cal.ac5_ac6[31:16]};
    assign ac6 = {16'd0, cal.ac5_ac6[15:0]};
    assign b1  = bpc_pkg::sext16(cal.b1_b2[31:16]);
    assign b2  = bpc_pkg::sext16(cal.b1_b2[15:0]);
    assign mc  = bpc_pkg::sext16(cal.mc_md[31:16]);
    assign md  = bpc_pkg::sext16(cal.mc_md[15:0]);

    // The whole pipe moves whenever the output register is free or drained.
    assign adv = !m_valid || m_ready;
    assign pop = adv;

    // Temperature front end.
    logic        a_vld_reg, b_vld_reg, c_vld_reg;
    logic [31:0] a_d_reg, b_m_reg, c_x1_reg, c_den_reg, c_num_reg;
    logic [15:0] a_up_reg, b_up_reg, c_up_reg;
    bpc_pkg::div1_side_t d_side_reg;
    logic [31:0] d_ua_reg, d_ub_reg;

    // Temperature divider and its context line.
    bpc_pkg::div1_side_t s1_reg [0:N-1];
    logic [31:0] q1;

    // Pressure stages.
    logic        e_vld_reg, e_err_reg;
    logic [15:0] e_t_reg, e_up_reg;
    logic [31:0] e_b6_reg;
    logic        f_vld_reg, f_err_reg;
    logic [15:0] f_t_reg, f_up_reg;
    logic [31:0] f_sqr_reg, f_a2m_reg, f_a3m_reg;
    logic        g_vld_reg, g_err_reg;
    logic [15:0] g_t_reg, g_up_reg;
    logic [31:0] g_sq_reg, g_x2a_reg, g_x1c_reg;
    logic        h_vld_reg, h_err_reg;
    logic [15:0] h_t_reg, h_up_reg;
    logic [31:0] h_m1_reg, h_m2_reg, h_x2a_reg, h_x1c_reg;
    logic        i_vld_reg, i_err_reg;
    logic [15:0] i_t_reg, i_up_reg;
    logic [31:0] i_b3_reg, i_x3b_reg;
    logic        j_vld_reg, j_err_reg;
    logic [15:0] j_t_reg;
    logic [31:0] j_b4_reg, j_dd_reg;
    logic        k_vld_reg, k_err_reg;
    logic [15:0] k_t_reg;
    logic [31:0] k_b4_reg, k_b7_reg;
    bpc_pkg::div2_side_t l_side_reg;
    logic [31:0] l_num_reg, l_den_reg;

    bpc_pkg::div2_side_t s2_reg [0:N-1];
    logic [31:0] q2;

    logic        m_vld_reg, m_err_reg;
    logic [15:0] m_t_reg;
    logic [31:0] m_p_reg;
    logic        n_vld_reg, n_err_reg;
    logic [15:0] n_t_reg;
    logic [31:0] n_p_reg, n_qq_reg, n_m7_reg;
    logic        o_vld_reg, o_err_reg;
    logic [15:0] o_t_reg;
    logic [31:0] o_p_reg, o_sq_reg, o_x2_reg;
    logic        p_vld_reg, p_err_reg;
    logic [15:0] p_t_reg;
    logic [31:0] p_p_reg, p_x1_reg, p_x2_reg;

    logic        out_vld_reg, out_err_reg;
    logic [15:0] out_t_reg;
    logic [31:0] out_p_reg;

    // Combinational values that feed the registers.
    logic [31:0] c_x1_next;
    logic [31:0] e_x2, e_b5, e_t32;
    logic [31:0] i_x1, i_x3, i_x2b;
    logic [31:0] j_m4;
    logic [31:0] fin_x1, fin_sum, fin_p;

    always_comb begin
        c_x1_next = bpc_pkg::sdiv_pow2(b_m_reg, 5'd15);

        e_x2  = s1_reg[N-1].neg ? (32'd0 - q1) : q1;
        e_b5  = s1_reg[N-1].x1 + e_x2;
        e_t32 = bpc_pkg::sdiv_pow2(e_b5 + bpc_pkg::C_TEMP_OFS, 5'd4);

        i_x1  = bpc_pkg::sdiv_pow2(h_m1_reg, 5'd11);
        i_x3  = i_x1 + h_x2a_reg;
        i_x2b = bpc_pkg::sdiv_pow2(h_m2_reg, 5'd16);

        j_m4  = ac4 * (i_x3b_reg + bpc_pkg::C_AC4_OFS);

        fin_x1  = bpc_pkg::sdiv_pow2(p_x1_reg, 5'd16);
        fin_sum = fin_x1 + p_x2_reg + bpc_pkg::C_P_OFS;
        fin_p   = p_p_reg + bpc_pkg::sdiv_pow2(fin_sum, 5'd4);
    end

    bpc_div u_div_temp (
        .aclk     (aclk),
        .en       (adv),
        .dividend (d_ua_reg),
        .divisor  (d_ub_reg),
        .quotient (q1)
    );

    bpc_div u_div_press (
        .aclk     (aclk),
        .en       (adv),
        .dividend (l_num_reg),
        .divisor  (l_den_reg),
        .quotient (q2)
    );

    // Valid bits of every stage and the context words beside the two dividers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_side_reg  <= '0;
            for (int i = 0; i < N; i++) begin
                s1_reg[i] <= '0;
                s2_reg[i] <= '0;
            end
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            i_vld_reg   <= 1'b0;
            j_vld_reg   <= 1'b0;
            k_vld_reg   <= 1'b0;
            l_side_reg  <= '0;
            m_vld_reg   <= 1'b0;
            n_vld_reg   <= 1'b0;
            o_vld_reg   <= 1'b0;
            p_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg   <= q_valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_side_reg.vld <= c_vld_reg;
            d_side_reg.err <= (c_den_reg == 32'd0);
            d_side_reg.neg <= c_num_reg[31] ^ c_den_reg[31];
            d_side_reg.x1  <= c_x1_reg;
            d_side_reg.up  <= c_up_reg;
            s1_reg[0] <= d_side_reg;
            s2_reg[0] <= l_side_reg;
            for (int i = 1; i < N; i++) begin
                s1_reg[i] <= s1_reg[i-1];
                s2_reg[i] <= s2_reg[i-1];
            end
            e_vld_reg   <= s1_reg[N-1].vld;
            f_vld_reg   <= e_vld_reg;
            g_vld_reg   <= f_vld_reg;
            h_vld_reg   <= g_vld_reg;
            i_vld_reg   <= h_vld_reg;
            j_vld_reg   <= i_vld_reg;
            k_vld_reg   <= j_vld_reg;
            l_side_reg.vld <= k_vld_reg;
            l_side_reg.err <= k_err_reg || (k_b4_reg == 32'd0);
            l_side_reg.big <= k_b7_reg[31];
            l_side_reg.t   <= k_t_reg;
            m_vld_reg   <= s2_reg[N-1].vld;
            n_vld_reg   <= m_vld_reg;
            o_vld_reg   <= n_vld_reg;
            p_vld_reg   <= o_vld_reg;
            out_vld_reg <= p_vld_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_d_reg  <= {16'd0, q_ut} - ac6;
            a_up_reg <= q_up;

            b_m_reg  <= a_d_reg * ac5;
            b_up_reg <= a_up_reg;

            c_x1_reg  <= c_x1_next;
            c_den_reg <= c_x1_next + md;
            c_num_reg <= mc << 11;
            c_up_reg  <= b_up_reg;

            d_ua_reg <= c_num_reg[31] ? (32'd0 - c_num_reg) : c_num_reg;
            d_ub_reg <= c_den_reg[31] ? (32'd0 - c_den_reg) : c_den_reg;

            e_err_reg <= s1_reg[N-1].err;
            e_t_reg   <= e_t32[15:0];
            e_up_reg  <= s1_reg[N-1].up;
            e_b6_reg  <= e_b5 - bpc_pkg::C_B6_OFS;

            f_err_reg <= e_err_reg;
            f_t_reg   <= e_t_reg;
            f_up_reg  <= e_up_reg;
            f_sqr_reg <= e_b6_reg * e_b6_reg;
            f_a2m_reg <= ac2 * e_b6_reg;
            f_a3m_reg <= ac3 * e_b6_reg;

            g_err_reg <= f_err_reg;
            g_t_reg   <= f_t_reg;
            g_up_reg  <= f_up_reg;
            g_sq_reg  <= bpc_pkg::sdiv_pow2(f_sqr_reg, 5'd12);
            g_x2a_reg <= bpc_pkg::sdiv_pow2(f_a2m_reg, 5'd11);
            g_x1c_reg <= bpc_pkg::sdiv_pow2(f_a3m_reg, 5'd13);

            h_err_reg <= g_err_reg;
            h_t_reg   <= g_t_reg;
            h_up_reg  <= g_up_reg;
            h_m1_reg  <= b2 * g_sq_reg;
            h_m2_reg  <= b1 * g_sq_reg;
            h_x2a_reg <= g_x2a_reg;
            h_x1c_reg <= g_x1c_reg;

            i_err_reg <= h_err_reg;
            i_t_reg   <= h_t_reg;
            i_up_reg  <= h_up_reg;
            i_b3_reg  <= bpc_pkg::sdiv_pow2((ac1 << 2) + i_x3 + bpc_pkg::C_ROUND2, 5'd2);
            i_x3b_reg <= bpc_pkg::sdiv_pow2(h_x1c_reg + i_x2b + bpc_pkg::C_ROUND2, 5'd2);

            j_err_reg <= i_err_reg;
            j_t_reg   <= i_t_reg;
            j_b4_reg  <= j_m4 >> 15;
            j_dd_reg  <= {16'd0, i_up_reg} - i_b3_reg;

            k_err_reg <= j_err_reg;
            k_t_reg   <= j_t_reg;
            k_b4_reg  <= j_b4_reg;
            k_b7_reg  <= j_dd_reg * bpc_pkg::C_UP_SCALE;

            // Below 2**31 the doubled value still fits, so double before dividing.
            l_num_reg <= k_b7_reg[31] ? k_b7_reg : (k_b7_reg << 1);
            l_den_reg <= k_b4_reg;

            m_err_reg <= s2_reg[N-1].err;
            m_t_reg   <= s2_reg[N-1].t;
            m_p_reg   <= s2_reg[N-1].big ? (q2 << 1) : q2;

            n_err_reg <= m_err_reg;
            n_t_reg   <= m_t_reg;
            n_p_reg   <= m_p_reg;
            n_qq_reg  <= bpc_pkg::sdiv_pow2(m_p_reg, 5'd8);
            n_m7_reg  <= bpc_pkg::C_P_LIN * m_p_reg;

            o_err_reg <= n_err_reg;
            o_t_reg   <= n_t_reg;
            o_p_reg   <= n_p_reg;
            o_sq_reg  <= n_qq_reg * n_qq_reg;
            o_x2_reg  <= bpc_pkg::sdiv_pow2(n_m7_reg, 5'd16);

            p_err_reg <= o_err_reg;
            p_t_reg   <= o_t_reg;
            p_p_reg   <= o_p_reg;
            p_x1_reg  <= o_sq_reg * bpc_pkg::C_P_SQ;
            p_x2_reg  <= o_x2_reg;

            out_err_reg <= p_err_reg;
            out_t_reg   <= p_err_reg ? 16'd0 : p_t_reg;
            out_p_reg   <= p_err_reg ? 32'd0 : fin_p;
        end
    end

    assign m_valid              = out_vld_reg;
    assign m_temperature_tenths = out_t_reg;
    assign m_pressure_pa        = out_p_reg;
    assign m_divide_error       = out_err_reg;

endmodule

`default_nettype wire

>>> rtl/core/baro_pressure_temp_compensation.sv
// Barometric temperature and pressure compensation, oversampling setting zero.
// A raw temperature and pressure pair is accepted into a four-entry queue and
// then runs through an 81-stage pipeline; one pair per cycle is sustained
// while results are taken. Most of the stages lie in the two pipelined 32-bit
// dividers, each of which resolves one quotient bit per stage. A zero divisor
// in either formula raises divide_error and returns zero temperature and
// pressure. The user must write calibration words through the APB port only
// while the block is idle; the block itself does not enforce this.
// Depends on bpc_pkg, bpc_regs, bpc_queue, bpc_div and bpc_back.
`default_nettype none

module baro_pressure_temp_compensation (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bpc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [15:0]                s_raw_temperature,
    input  wire logic [15:0]                s_raw_pressure,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [15:0]              m_temperature_tenths,
    output logic signed [31:0]              m_pressure_pa,
    output logic                            m_divide_error
);

    bpc_pkg::cal_t cal;
    logic        q_valid;
    logic [15:0] q_ut, q_up;
    logic        pop;
    logic [15:0] temp_bits;
    logic [31:0] press_bits;

    bpc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    bpc_queue u_queue (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_raw_temperature (s_raw_temperature),
        .s_raw_pressure    (s_raw_pressure),
        .pop               (pop),
        .q_valid           (q_valid),
        .q_ut              (q_ut),
        .q_up              (q_up)
    );

    bpc_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cal                  (cal),
        .q_valid              (q_valid),
        .q_ut                 (q_ut),
        .q_up                 (q_up),
        .pop                  (pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_temperature_tenths (temp_bits),
        .m_pressure_pa        (press_bits),
        .m_divide_error       (m_divide_error)
    );

    assign m_temperature_tenths = $signed(temp_bits);
    assign m_pressure_pa        = $signed(press_bits);

endmodule

`default_nettype wire

>>> rtl/core/bpc_checker.sv
// Port-level checks for the compensation block, bound to the top level.
// Depends on bpc_pkg for the address width.
`default_nettype none

module bpc_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       pready,
    input wire logic [bpc_pkg::ADDR_W-1:0] paddr,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic signed [15:0]         m_temperature_tenths,
    input wire logic signed [31:0]         m_pressure_pa,
    input wire logic                       m_divide_error
);

    // A divide error always comes with both results cleared.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_divide_error) |-> (m_temperature_tenths == 16'sd0 &&
                                         m_pressure_pa == 32'sd0))
        else $error("divide error with nonzero results");

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pressure_pa) &&
                                   $stable(m_temperature_tenths)))
        else $error("stalled result changed");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        $stable(paddr) |-> pready)
        else $error("pready dropped");

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .pready               (pready),
    .paddr                (paddr),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_temperature_tenths (m_temperature_tenths),
    .m_pressure_pa        (m_pressure_pa),
    .m_divide_error       (m_divide_error)
);

`default_nettype wire

>>> tb/tb_baro_pressure_temp_compensation.sv
// Testbench for the barometric temperature and pressure compensation block.
// Drives calibration words over APB and raw sample pairs over valid/ready, and
// checks each result against an in-bench model. Depends on bpc_pkg and the RTL.
`default_nettype none

module tb_baro_pressure_temp_compensation;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [bpc_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_raw_temperature = '0, s_raw_pressure = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [15:0] m_temperature_tenths;
    logic signed [31:0] m_pressure_pa;
    logic        m_divide_error;

    baro_pressure_temp_compensation i_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    typedef struct {
        logic [15:0] t;
        logic [31:0] p;
        logic        err;
    } comp_t;

    typedef struct {
        logic [15:0] ut;
        logic [15:0] up;
        logic        known;
        comp_t       res;
    } row_t;

    logic [31:0] cal_word [5];
    comp_t       pending_q [$];
    int          errors = 0;
    int          results_seen = 0;
    int          sent = 0;
    longint      cycles = 0;
    int          src_idle = 28, snk_idle = 62;
    bit          finished = 0;

    function automatic logic [31:0] sdiv32(logic [31:0] a, logic [31:0] b);
        logic [31:0] ua, ub, q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q  = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] sx(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic comp_t compensate(logic [15:0] ut16, logic [15:0] up16);
        comp_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b7, sq, t, p, q;
        ac1 = sx(cal_word[bpc_pkg::REG_AC1_AC2][31:16]);
        ac2 = sx(cal_word[bpc_pkg::REG_AC1_AC2][15:0]);
        ac3 = sx(cal_word[bpc_pkg::REG_AC3_AC4][31:16]);
        ac4 = {16'd0, cal_word[bpc_pkg::REG_AC3_AC4][15:0]};
        ac5 = {16'd0, cal_word[bpc_pkg::REG_AC5_AC6][31:16]};
        ac6 = {16'd0, cal_word[bpc_pkg::REG_AC5_AC6][15:0]};
        b1 = sx(cal_word[bpc_pkg::REG_B1_B2][31:16]);
        b2 = sx(cal_word[bpc_pkg::REG_B1_B2][15:0]);
        mc = sx(cal_word[bpc_pkg::REG_MC_MD][31:16]);
        md = sx(cal_word[bpc_pkg::REG_MC_MD][15:0]);
        r = '{16'd0, 32'd0, 1'b1};
        x1 = sdiv32(({16'd0, ut16} - ac6) * ac5, 32'd32768);
        den = x1 + md;
        if (den == 0) return r;
        x2 = sdiv32(mc * 32'd2048, den);
        b5 = x1 + x2;
        t = sdiv32(b5 + 32'd8, 32'd16);
        b6 = b5 - 32'd4000;
        sq = sdiv32(b6 * b6, 32'd4096);
        x1 = sdiv32(b2 * sq, 32'd2048);
        x2 = sdiv32(ac2 * b6, 32'd2048);
        x3 = x1 + x2;
        b3 = sdiv32(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
        x1 = sdiv32(ac3 * b6, 32'd8192);
        x2 = sdiv32(b1 * sq, 32'd65536);
        x3 = sdiv32(x1 + x2 + 32'd2, 32'd4);
        b4 = (ac4 * (x3 + 32'd32768)) / 32'd32768;
        if (b4 == 0) return r;
        b7 = ({16'd0, up16} - b3) * 32'd50000;
        if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        q = sdiv32(p, 32'd256);
        x1 = sdiv32((q * q) * 32'd3038, 32'd65536);
        x2 = sdiv32(32'hFFFF_E343 * p, 32'd65536);
        p = p + sdiv32(x1 + x2 + 32'd3791, 32'd16);
        r = '{t[15:0], p, 1'b0};
        return r;
    endfunction

    // Receiver side: random stall and comparison against the oldest expectation.
    always @(posedge aclk) begin
        comp_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result t=%0d p=%0d err=%0b", $realtime,
                         m_temperature_tenths, m_pressure_pa, m_divide_error);
                errors <= errors + 1;
            end else begin
                e = pending_q.pop_front();
                if (m_temperature_tenths !== e.t || m_pressure_pa !== e.p ||
                    m_divide_error !== e.err) begin
                    $display("%0t: mismatch expected t=%0d p=%0d err=%0b, got t=%0d p=%0d err=%0b",
                             $realtime, $signed(e.t), $signed(e.p), e.err,
                             m_temperature_tenths, m_pressure_pa, m_divide_error);
                    errors <= errors + 1;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge aclk) begin
        if (cycles > 400000 && !finished) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic apb_write(bpc_pkg::reg_idx_t idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= bpc_pkg::ADDR_W'(4 * int'(idx)); pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cal_word[idx] = value;
    endtask

    // Sends one pair and records the expectation once the transfer happens.
    // Valid stays up between back-to-back pairs and drops only while idling.
    task automatic send_pair(logic [15:0] ut, logic [15:0] up, logic known, comp_t res);
        comp_t exp_res;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        exp_res = known ? res : compensate(ut, up);
        s_valid <= 1'b1; s_raw_temperature <= ut; s_raw_pressure <= up;
        do @(posedge aclk); while (!s_ready);
        pending_q.push_back(exp_res);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Typical factory calibration, each field perturbed; random words if wild.
    task automatic load_cal(bit wild);
        logic [31:0] w [5];
        bpc_pkg::reg_idx_t idx;
        if (wild) begin
            foreach (w[i]) w[i] = $urandom;
        end else begin
            w[bpc_pkg::REG_AC1_AC2] = {16'd408 + 16'($urandom_range(63)),
                                       16'hFCA9 - 16'($urandom_range(63))};
            w[bpc_pkg::REG_AC3_AC4] = {16'hC6D1 + 16'($urandom_range(63)),
                                       16'd32741 + 16'($urandom_range(2000))};
            w[bpc_pkg::REG_AC5_AC6] = {16'd32757 - 16'($urandom_range(9000)),
                                       16'd23153 + 16'($urandom_range(2000))};
            w[bpc_pkg::REG_B1_B2]   = {16'd6190 + 16'($urandom_range(63)),
                                       16'd4 + 16'($urandom_range(63))};
            w[bpc_pkg::REG_MC_MD]   = {16'hD4BD - 16'($urandom_range(255)),
                                       16'd2868 + 16'($urandom_range(255))};
        end
        for (int i = 0; i < 5; i++) begin
            idx = bpc_pkg::reg_idx_t'(i);
            apb_write(idx, w[i]);
        end
    endtask

    initial begin
        row_t table_rows [$];
        comp_t zero_err;
        int burst;
        zero_err = '{16'd0, 32'd0, 1'b1};
        foreach (cal_word[i]) cal_word[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // After reset every word is zero, so the first divisor is zero.
        table_rows.push_back('{16'h0000, 16'h0000, 1'b1, zero_err});
        table_rows.push_back('{16'hFFFF, 16'hFFFF, 1'b1, zero_err});
        table_rows.push_back('{16'h8000, 16'h7FFF, 1'b1, zero_err});
        foreach (table_rows[i])
            send_pair(table_rows[i].ut, table_rows[i].up, table_rows[i].known, table_rows[i].res);
        drain();

        // Zero ac4 with nonzero md gives a zero pressure divisor.
        apb_write(bpc_pkg::REG_MC_MD, 32'h0000_0B34);
        send_pair(16'd27898, 16'd23843, 1'b1, zero_err);
        drain();

        table_rows.delete();
        table_rows.push_back('{16'd27898, 16'd23843, 1'b0, zero_err});
        table_rows.push_back('{16'h0000, 16'h0000, 1'b0, zero_err});
        table_rows.push_back('{16'hFFFF, 16'hFFFF, 1'b0, zero_err});
        table_rows.push_back('{16'h5555, 16'hAAAA, 1'b0, zero_err});
        table_rows.push_back('{16'hAAAA, 16'h5555, 1'b0, zero_err});
        table_rows.push_back('{16'h7FFF, 16'h8000, 1'b0, zero_err});
        load_cal(0);
        foreach (table_rows[i])
            send_pair(table_rows[i].ut, table_rows[i].up, 1'b0, zero_err);
        drain();
        // Extreme words: wraparound in every product, most-negative division.
        apb_write(bpc_pkg::REG_AC1_AC2, 32'h8000_8000);
        apb_write(bpc_pkg::REG_AC3_AC4, 32'h8000_FFFF);
        apb_write(bpc_pkg::REG_AC5_AC6, 32'hFFFF_FFFF);
        apb_write(bpc_pkg::REG_B1_B2, 32'h7FFF_7FFF);
        apb_write(bpc_pkg::REG_MC_MD, 32'h8000_7FFF);
        foreach (table_rows[i])
            send_pair(table_rows[i].ut, table_rows[i].up, 1'b0, zero_err);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle = (phase == 0) ? 28 : (phase == 1) ? 62 : 0;
            snk_idle = (phase == 0) ? 62 : (phase == 1) ? 28 : 0;
            for (int s = 0; s < 3; s++) begin
                load_cal(s == 2);
                burst = 150;
                for (int k = 0; k < burst; k++) begin
                    send_pair(16'($urandom), 16'($urandom), 1'b0, zero_err);
                    // Hold the sender back until the block is empty once.
                    if (k == 75 && s == 0) begin
                        s_valid <= 1'b0;
                        while (pending_q.size() != 0) @(posedge aclk);
                    end
                end
                drain();
            end
        end

        finished = 1;
        $display("Sent %0d sample pairs over %0d cycles, %0d results checked,", sent,
                 cycles, results_seen);
        $display("with reset, extreme, random and field-plausible calibrations.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
